### hw/rtl/deq_pkg.sv
// shared types, constants and index helpers for the double-ended queue
`timescale 1ns / 1ps

package deq_pkg;

	localparam int DEPTH      = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int SUM_W      = CNT_W + 1;
	localparam int DATA_W     = 32;
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [2:0] ACT_POP_BACK   = 3'd3;
	localparam logic [2:0] ACT_DUMP_FWD   = 3'd4;
	localparam logic [2:0] ACT_DUMP_BWD   = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] value;
	} deq_req_t;

	typedef struct packed {
		logic signed [31:0] element;
		logic [1:0]         status;
		logic               last;
	} deq_rsp_t;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_DUMP_FWD,
		OP_DUMP_BWD
	} deq_op_t;

	typedef struct packed {
		deq_op_t            op;
		logic signed [31:0] value;
	} deq_cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_DUMP
	} deq_state_t;

	// ring position of base + off, with off below DEPTH
	function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
		input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(DEPTH)) begin
			sum = sum - SUM_W'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] base);
		logic [IDX_W-1:0] res;
		if (base == '0) begin
			res = IDX_W'(DEPTH - 1);
		end else begin
			res = base - IDX_W'(1);
		end
		return res;
	endfunction

endpackage

### hw/rtl/deq_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/deq_front.sv
// request intake: decodes actions and buffers commands in a short queue
`timescale 1ns / 1ps

module deq_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  deq_pkg::deq_req_t req,
	output logic              cmd_valid,
	output deq_pkg::deq_cmd_t cmd,
	input  logic              cmd_pop
);

	deq_pkg::deq_cmd_t                  entry_q [deq_pkg::CMDQ_DEPTH];
	logic [deq_pkg::CMDQ_PTR_W-1:0]     wr_q;
	logic [deq_pkg::CMDQ_PTR_W-1:0]     rd_q;
	logic [deq_pkg::CMDQ_CNT_W-1:0]     count_q;
	logic                               act_ok;
	deq_pkg::deq_op_t                   op;
	logic                               push;

	always_comb begin
		act_ok = 1'b1;
		op     = deq_pkg::OP_PUSH_FRONT;
		unique case (req.action)
			deq_pkg::ACT_PUSH_FRONT: op = deq_pkg::OP_PUSH_FRONT;
			deq_pkg::ACT_PUSH_BACK:  op = deq_pkg::OP_PUSH_BACK;
			deq_pkg::ACT_POP_FRONT:  op = deq_pkg::OP_POP_FRONT;
			deq_pkg::ACT_POP_BACK:   op = deq_pkg::OP_POP_BACK;
			deq_pkg::ACT_DUMP_FWD:   op = deq_pkg::OP_DUMP_FWD;
			deq_pkg::ACT_DUMP_BWD:   op = deq_pkg::OP_DUMP_BWD;
			default:                 act_ok = 1'b0;
		endcase
	end

	assign req_ready = (count_q != deq_pkg::CMDQ_CNT_W'(deq_pkg::CMDQ_DEPTH));
	assign push      = req_valid && req_ready && act_ok;
	assign cmd_valid = (count_q != '0);
	assign cmd       = entry_q[rd_q];

	function automatic logic [deq_pkg::CMDQ_PTR_W-1:0] ptr_inc(
		input logic [deq_pkg::CMDQ_PTR_W-1:0] p);
		logic [deq_pkg::CMDQ_PTR_W-1:0] res;
		if (p == deq_pkg::CMDQ_PTR_W'(deq_pkg::CMDQ_DEPTH - 1)) begin
			res = '0;
		end else begin
			res = p + deq_pkg::CMDQ_PTR_W'(1);
		end
		return res;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= '{op: op, value: req.value};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_inc(wr_q);
			end
			if (cmd_pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + deq_pkg::CMDQ_CNT_W'(1);
			end else if (!push && cmd_pop) begin
				count_q <= count_q - deq_pkg::CMDQ_CNT_W'(1);
			end
		end
	end

endmodule

### hw/rtl/deq_back.sv
// command execution: ring store, pointers, dump sequencer and result register
`timescale 1ns / 1ps

module deq_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  deq_pkg::deq_cmd_t cmd,
	output logic              cmd_pop,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output deq_pkg::deq_rsp_t rsp
);

	deq_pkg::deq_state_t            state_q;
	deq_pkg::deq_state_t            state_d;
	logic [deq_pkg::IDX_W-1:0]      front_q;
	logic [deq_pkg::IDX_W-1:0]      front_d;
	logic [deq_pkg::CNT_W-1:0]      occ_q;
	logic [deq_pkg::CNT_W-1:0]      occ_d;
	logic [deq_pkg::CNT_W-1:0]      cnt_q;
	logic [deq_pkg::CNT_W-1:0]      cnt_d;
	logic                           bwd_q;
	logic                           bwd_d;
	logic                           rsp_valid_q;
	deq_pkg::deq_rsp_t              rsp_q;
	logic                           load;
	deq_pkg::deq_rsp_t              load_rsp;

	logic                           out_free;
	logic                           is_empty;
	logic                           is_full;
	logic                           dump_last;
	logic                           cmd_bwd;
	logic                           rd_bwd;
	logic [deq_pkg::CNT_W-1:0]      nxt_cnt;
	logic [deq_pkg::CNT_W-1:0]      rd_off;
	logic [deq_pkg::IDX_W-1:0]      dump_addr;

	logic                           ram_we;
	logic [deq_pkg::IDX_W-1:0]      ram_waddr;
	logic                           ram_re;
	logic [deq_pkg::IDX_W-1:0]      ram_raddr;
	logic [deq_pkg::DATA_W-1:0]     ram_rdata;

	deq_ram #(
		.WIDTH(deq_pkg::DATA_W),
		.DEPTH(deq_pkg::DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(cmd.value),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign is_empty  = (occ_q == '0);
	assign is_full   = (occ_q == deq_pkg::CNT_W'(deq_pkg::DEPTH));
	assign dump_last = ((cnt_q + deq_pkg::CNT_W'(1)) == occ_q);
	assign cmd_bwd   = (cmd.op == deq_pkg::OP_DUMP_BWD);

	// element read next: first one when starting, following one when streaming
	assign rd_bwd    = (state_q == deq_pkg::S_DUMP) ? bwd_q : cmd_bwd;
	assign nxt_cnt   = (state_q == deq_pkg::S_DUMP) ? cnt_q + deq_pkg::CNT_W'(1) : '0;
	assign rd_off    = rd_bwd ? occ_q - deq_pkg::CNT_W'(1) - nxt_cnt : nxt_cnt;
	assign dump_addr = deq_pkg::ring_pos(front_q, rd_off);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			deq_pkg::S_IDLE: begin
				if (cmd_valid && out_free && !is_empty) begin
					unique case (cmd.op)
						deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: state_d = deq_pkg::S_POP;
						deq_pkg::OP_DUMP_FWD, deq_pkg::OP_DUMP_BWD:  state_d = deq_pkg::S_DUMP;
						default:                                     state_d = deq_pkg::S_IDLE;
					endcase
				end
			end
			deq_pkg::S_POP: begin
				if (out_free) begin
					state_d = deq_pkg::S_IDLE;
				end
			end
			deq_pkg::S_DUMP: begin
				if (out_free && dump_last) begin
					state_d = deq_pkg::S_IDLE;
				end
			end
			default: state_d = deq_pkg::S_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		cmd_pop   = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = front_q;
		ram_re    = 1'b0;
		ram_raddr = dump_addr;
		load      = 1'b0;
		load_rsp  = '{element: '0, status: deq_pkg::ST_OK, last: 1'b1};
		front_d   = front_q;
		occ_d     = occ_q;
		cnt_d     = cnt_q;
		bwd_d     = bwd_q;
		unique case (state_q)
			deq_pkg::S_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_pop = 1'b1;
					load    = 1'b1;
					unique case (cmd.op)
						deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
							if (is_full) begin
								load_rsp.status = deq_pkg::ST_FULL;
							end else begin
								ram_we = 1'b1;
								occ_d  = occ_q + deq_pkg::CNT_W'(1);
								if (cmd.op == deq_pkg::OP_PUSH_FRONT) begin
									ram_waddr = deq_pkg::ring_dec(front_q);
									front_d   = deq_pkg::ring_dec(front_q);
								end else begin
									ram_waddr = deq_pkg::ring_pos(front_q, occ_q);
								end
							end
						end
						deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
							if (is_empty) begin
								load_rsp.status = deq_pkg::ST_EMPTY;
							end else begin
								load   = 1'b0;
								ram_re = 1'b1;
								occ_d  = occ_q - deq_pkg::CNT_W'(1);
								if (cmd.op == deq_pkg::OP_POP_FRONT) begin
									ram_raddr = front_q;
									front_d   = deq_pkg::ring_pos(front_q, deq_pkg::CNT_W'(1));
								end else begin
									ram_raddr = deq_pkg::ring_pos(front_q,
										occ_q - deq_pkg::CNT_W'(1));
								end
							end
						end
						deq_pkg::OP_DUMP_FWD, deq_pkg::OP_DUMP_BWD: begin
							if (is_empty) begin
								load_rsp.status = deq_pkg::ST_EMPTY;
							end else begin
								load   = 1'b0;
								ram_re = 1'b1;
								cnt_d  = '0;
								bwd_d  = cmd_bwd;
							end
						end
						default: load = 1'b0;
					endcase
				end
			end
			deq_pkg::S_POP: begin
				if (out_free) begin
					load             = 1'b1;
					load_rsp.element = ram_rdata;
				end
			end
			deq_pkg::S_DUMP: begin
				if (out_free) begin
					load             = 1'b1;
					load_rsp.element = ram_rdata;
					load_rsp.last    = dump_last;
					if (!dump_last) begin
						ram_re = 1'b1;
						cnt_d  = nxt_cnt;
					end
				end
			end
			default: load = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		cnt_q <= cnt_d;
		bwd_q <= bwd_d;
		if (load) begin
			rsp_q <= load_rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= deq_pkg::S_IDLE;
			front_q     <= '0;
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			occ_q   <= occ_d;
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### hw/rtl/double_ended_queue_unit.sv
// top level of the double-ended queue
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values in a 32-entry ring store.
// Request channel req_valid/req_ready carries req (action, value); action codes
// six and seven are taken and dropped without a response. Response channel
// rsp_valid/rsp_ready carries rsp (element, status, last); every other action
// gives one response, a dump of a non-empty queue gives one per stored element
// with last set on the final one.
// A request enters a two-entry command queue and is executed from there; the
// response is registered, and for a pop or dump of a non-empty queue the
// registered ring read comes before it. Pushes are taken one per cycle while
// the response register is free; a pop or dump holds the back end in S_POP or
// S_DUMP, and no new command starts until it is through.
// When rsp_ready is low the response register holds its transfer, the back end
// waits, and requests keep being taken until the command queue is full.
// Reset empties the queue and the command queue; front pointer returns to zero.

module double_ended_queue_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  deq_pkg::deq_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output deq_pkg::deq_rsp_t rsp
);

	logic              cmd_valid;
	logic              cmd_pop;
	deq_pkg::deq_cmd_t cmd;

	deq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	deq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

### tb/double_ended_queue_unit_test.sv
// self-checking testbench for double_ended_queue_unit
`timescale 1ns / 1ps

module double_ended_queue_unit_test;

	localparam logic [2:0] ACT_SPARE_A = 3'd6;
	localparam logic [2:0] ACT_SPARE_B = 3'd7;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 150;

	typedef struct {
		logic [2:0]         action;
		logic signed [31:0] value;
		int                 reps;
		bit                 typed;
		deq_pkg::deq_rsp_t  want;
	} plan_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_ready;
	deq_pkg::deq_req_t req = '0;
	logic              rsp_valid;
	logic              rsp_ready = 1'b0;
	deq_pkg::deq_rsp_t rsp;

	logic signed [31:0] mirror_ring [deq_pkg::DEPTH];
	int mirror_head = 0;
	int mirror_fill = 0;
	deq_pkg::deq_rsp_t awaited_rsp[$];

	bit calm = 1'b0;
	bit steady = 1'b0;
	bit fill_mode = 1'b1;
	int hold_request = 0;
	int stall_left = 0;
	int cycles = 0;
	int accepted = 0;
	int checked = 0;
	int mismatches = 0;
	int full_seen = 0;
	int empty_seen = 0;
	int peak_fill = 0;
	plan_row_t plan[$];

	double_ended_queue_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("double_ended_queue_unit test failed");
			$finish;
		end
	end

	function automatic deq_pkg::deq_rsp_t rsp_of(input logic signed [31:0] el,
		input logic [1:0] st, input logic lst);
		deq_pkg::deq_rsp_t r;
		r.element = el;
		r.status  = st;
		r.last    = lst;
		return r;
	endfunction

	function automatic plan_row_t step_row(input logic [2:0] a, input logic signed [31:0] v,
		input int reps, input bit typed, input logic signed [31:0] el, input logic [1:0] st);
		plan_row_t p;
		p.action = a;
		p.value  = v;
		p.reps   = reps;
		p.typed  = typed;
		p.want   = rsp_of(el, st, 1'b1);
		return p;
	endfunction

	// shadow deque: update state and queue up the responses one request owes
	task automatic mirror_apply(input logic [2:0] a, input logic signed [31:0] v);
		int i;
		int off;
		logic signed [31:0] got;
		case (a)
			deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_BACK: begin
				if (mirror_fill == deq_pkg::DEPTH) begin
					awaited_rsp.push_back(rsp_of('0, deq_pkg::ST_FULL, 1'b1));
				end else begin
					if (a == deq_pkg::ACT_PUSH_FRONT) begin
						mirror_head = (mirror_head + deq_pkg::DEPTH - 1) % deq_pkg::DEPTH;
						mirror_ring[mirror_head] = v;
					end else begin
						mirror_ring[(mirror_head + mirror_fill) % deq_pkg::DEPTH] = v;
					end
					mirror_fill++;
					if (mirror_fill > peak_fill) begin
						peak_fill = mirror_fill;
					end
					awaited_rsp.push_back(rsp_of('0, deq_pkg::ST_OK, 1'b1));
				end
			end
			deq_pkg::ACT_POP_FRONT, deq_pkg::ACT_POP_BACK: begin
				if (mirror_fill == 0) begin
					awaited_rsp.push_back(rsp_of('0, deq_pkg::ST_EMPTY, 1'b1));
				end else begin
					if (a == deq_pkg::ACT_POP_FRONT) begin
						got = mirror_ring[mirror_head];
						mirror_head = (mirror_head + 1) % deq_pkg::DEPTH;
					end else begin
						got = mirror_ring[(mirror_head + mirror_fill - 1) % deq_pkg::DEPTH];
					end
					mirror_fill--;
					awaited_rsp.push_back(rsp_of(got, deq_pkg::ST_OK, 1'b1));
				end
			end
			deq_pkg::ACT_DUMP_FWD, deq_pkg::ACT_DUMP_BWD: begin
				if (mirror_fill == 0) begin
					awaited_rsp.push_back(rsp_of('0, deq_pkg::ST_EMPTY, 1'b1));
				end else begin
					for (i = 0; i < mirror_fill; i++) begin
						off = (a == deq_pkg::ACT_DUMP_FWD) ? i : mirror_fill - 1 - i;
						awaited_rsp.push_back(rsp_of(
							mirror_ring[(mirror_head + off) % deq_pkg::DEPTH],
							deq_pkg::ST_OK, i == mirror_fill - 1));
					end
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic offer(input logic [2:0] a, input logic signed [31:0] v, input bit typed,
		input deq_pkg::deq_rsp_t want);
		int gap;
		gap = 0;
		if (!calm && !steady && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 18);
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= deq_pkg::deq_req_t'{action: a, value: v};
		do @(posedge clk); while (!req_ready);
		accepted++;
		mirror_apply(a, v);
		if (typed) begin
			void'(awaited_rsp.pop_back());
			awaited_rsp.push_back(want);
		end
	endtask

	task automatic send_random(input int n);
		int k;
		int roll;
		logic [2:0] a;
		logic signed [31:0] v;
		for (k = 0; k < n; k++) begin
			if (fill_mode && mirror_fill == deq_pkg::DEPTH && $urandom_range(0, 3) == 0) begin
				fill_mode = 1'b0;
			end else if (!fill_mode && mirror_fill == 0 && $urandom_range(0, 3) == 0) begin
				fill_mode = 1'b1;
			end
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				a = roll[0] ? ACT_SPARE_B : ACT_SPARE_A;
			end else if (roll < 12) begin
				a = roll[0] ? deq_pkg::ACT_DUMP_BWD : deq_pkg::ACT_DUMP_FWD;
			end else if ((roll < 75) == fill_mode) begin
				a = roll[0] ? deq_pkg::ACT_PUSH_BACK : deq_pkg::ACT_PUSH_FRONT;
			end else begin
				a = roll[0] ? deq_pkg::ACT_POP_BACK : deq_pkg::ACT_POP_FRONT;
			end
			case ($urandom_range(0, 7))
				0: v = 32'sh7fff_ffff;
				1: v = 32'sh8000_0000;
				2: v = '0;
				3: v = '1;
				default: v = $urandom;
			endcase
			offer(a, v, 1'b0, '0);
		end
	endtask

	// response side: check each transfer, then pick ready for the next cycle
	always @(posedge clk) begin
		deq_pkg::deq_rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_rsp.size() == 0) begin
				if (mismatches < 10) begin
					$display("unexpected response element=%0d status=%0d last=%0b",
						rsp.element, rsp.status, rsp.last);
				end
				mismatches++;
			end else begin
				want = awaited_rsp.pop_front();
				checked++;
				if (rsp.status == deq_pkg::ST_FULL) begin
					full_seen++;
				end
				if (rsp.status == deq_pkg::ST_EMPTY) begin
					empty_seen++;
				end
				if (rsp.element !== want.element || rsp.status !== want.status ||
					rsp.last !== want.last) begin
					if (mismatches < 10) begin
						$display("mismatch at response %0d: expected %0d/%0d/%0b got %0d/%0d/%0b",
							checked, want.element, want.status, want.last,
							rsp.element, rsp.status, rsp.last);
					end
					mismatches++;
				end
			end
		end
		if (hold_request != 0) begin
			stall_left = hold_request;
			hold_request = 0;
		end
		if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left--;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 18) - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	initial begin
		int r;
		int k;
		plan = '{
			step_row(deq_pkg::ACT_POP_FRONT, 0, 1, 1'b1, 0, deq_pkg::ST_EMPTY),
			step_row(deq_pkg::ACT_POP_BACK, 0, 1, 1'b1, 0, deq_pkg::ST_EMPTY),
			step_row(deq_pkg::ACT_DUMP_FWD, 0, 1, 1'b1, 0, deq_pkg::ST_EMPTY),
			step_row(deq_pkg::ACT_DUMP_BWD, 0, 1, 1'b1, 0, deq_pkg::ST_EMPTY),
			step_row(deq_pkg::ACT_PUSH_FRONT, 32'sh7fff_ffff, 1, 1'b1, 0, deq_pkg::ST_OK),
			step_row(deq_pkg::ACT_PUSH_BACK, 32'sh8000_0000, 1, 1'b1, 0, deq_pkg::ST_OK),
			step_row(deq_pkg::ACT_PUSH_FRONT, 0, 1, 1'b1, 0, deq_pkg::ST_OK),
			step_row(deq_pkg::ACT_PUSH_BACK, -1, 1, 1'b1, 0, deq_pkg::ST_OK),
			step_row(deq_pkg::ACT_DUMP_FWD, 0, 1, 1'b0, 0, deq_pkg::ST_OK),
			step_row(deq_pkg::ACT_DUMP_BWD, 0, 1, 1'b0, 0, deq_pkg::ST_OK),
			step_row(ACT_SPARE_A, 32'sh5a5a_5a5a, 1, 1'b0, 0, deq_pkg::ST_OK),
			step_row(ACT_SPARE_B, -1, 1, 1'b0, 0, deq_pkg::ST_OK),
			step_row(deq_pkg::ACT_POP_FRONT, 0, 1, 1'b1, 0, deq_pkg::ST_OK),
			step_row(deq_pkg::ACT_POP_BACK, 0, 1, 1'b1, -1, deq_pkg::ST_OK),
			step_row(deq_pkg::ACT_POP_FRONT, 0, 1, 1'b1, 32'sh7fff_ffff, deq_pkg::ST_OK),
			step_row(deq_pkg::ACT_POP_BACK, 0, 1, 1'b1, 32'sh8000_0000, deq_pkg::ST_OK),
			step_row(deq_pkg::ACT_POP_FRONT, 0, 1, 1'b1, 0, deq_pkg::ST_EMPTY),
			step_row(deq_pkg::ACT_PUSH_BACK, 32'sh0000_1000, deq_pkg::DEPTH - 1, 1'b0, 0,
				deq_pkg::ST_OK),
			step_row(deq_pkg::ACT_PUSH_FRONT, 32'sh1234_5678, 1, 1'b1, 0, deq_pkg::ST_OK),
			step_row(deq_pkg::ACT_PUSH_FRONT, 0, 1, 1'b1, 0, deq_pkg::ST_FULL),
			step_row(deq_pkg::ACT_PUSH_BACK, -1, 1, 1'b1, 0, deq_pkg::ST_FULL),
			step_row(deq_pkg::ACT_DUMP_FWD, 0, 1, 1'b0, 0, deq_pkg::ST_OK),
			step_row(deq_pkg::ACT_DUMP_BWD, 0, 1, 1'b0, 0, deq_pkg::ST_OK),
			step_row(deq_pkg::ACT_POP_FRONT, 0, 4, 1'b0, 0, deq_pkg::ST_OK),
			step_row(deq_pkg::ACT_POP_BACK, 0, 4, 1'b0, 0, deq_pkg::ST_OK)
		};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (r = 0; r < plan.size(); r++) begin
			for (k = 0; k < plan[r].reps; k++) begin
				offer(plan[r].action, plan[r].value + k, plan[r].typed, plan[r].want);
			end
		end

		send_random(100);

		// drain everything before going on
		req_valid <= 1'b0;
		do @(posedge clk); while (awaited_rsp.size() != 0);

		// long receiver hold while requests keep coming
		hold_request = HOLD_CYCLES;
		steady = 1'b1;
		send_random(20);
		steady = 1'b0;

		send_random(60);

		calm = 1'b1;
		send_random(30);

		req_valid <= 1'b0;
		do @(posedge clk); while (awaited_rsp.size() != 0);
		repeat (10) @(posedge clk);

		$display("%0d requests accepted, %0d responses checked, peak occupancy %0d of %0d",
			accepted, checked, peak_fill, deq_pkg::DEPTH);
		$display("%0d full drops and %0d empty reports seen, %0d mismatches",
			full_seen, empty_seen, mismatches);
		if (mismatches == 0 && awaited_rsp.size() == 0) begin
			$display("double_ended_queue_unit test passed");
		end else begin
			$display("double_ended_queue_unit test failed");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/deq_pkg.sv
hw/rtl/deq_ram.sv
hw/rtl/deq_front.sv
hw/rtl/deq_back.sv
hw/rtl/double_ended_queue_unit.sv
tb/double_ended_queue_unit_test.sv
